// ===== hdl/efr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg
// Shared constants and types for the exponential decay FIR reverb unit.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int SEGMENT_COUNT_DEF = 4;
  localparam int SEGMENT_TAPS_DEF  = 16;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W + 1;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_GAIN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY_RATIO = 1'b1;

  localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd32768;
  localparam logic [COEF_W-1:0] RATIO_RESET = 16'd58982;

  // +-0.99 full scale in Q31
  localparam longint CLAMP_LIM = 64'sd2126008810;

  typedef struct packed {
    logic start;
    logic tap_vld;
    logic tap_last;
  } efr_mac_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/efr_hist_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efr_hist_mem
// Sample history store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module efr_hist_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/efr_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efr_mac
// Coefficient recurrence, tap multiply-accumulate, clamp and Q47->Q31 round.
// ----------------------------------------------------------------------------
module efr_mac #(
  parameter int TAPS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire efr_pkg::efr_mac_ctl_t         ctl,
  input  wire logic [efr_pkg::SAMPLE_W-1:0]  tap_data,
  input  wire logic [efr_pkg::COEF_W-1:0]    gain,
  input  wire logic [efr_pkg::COEF_W-1:0]    ratio,
  output logic                               res_vld_r,
  output logic [efr_pkg::SAMPLE_W-1:0]       res_sample_r,
  output logic                               res_clip_r
);
  import efr_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS + 1);
  localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(CLAMP_LIM) << 16;
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(32768);

  logic [COEF_W-1:0]          coef_r;
  logic [2*COEF_W-1:0]        coef_mul;
  logic [COEF_W-1:0]          coef_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r;
  logic                       prod_last_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       acc_done_r;
  logic signed [ACC_W-1:0]    sat_r;
  logic                       sat_clip_r;
  logic                       sat_vld_r;
  logic signed [ACC_W-1:0]    rnd;

  // coef[n+1] = round_half_up(coef[n] * ratio / 2^16)
  assign coef_mul = coef_r * ratio + 32'd32768;
  assign coef_nxt = coef_mul[2*COEF_W-1:COEF_W];

  assign rnd = sat_r + HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r  <= 1'b0;
      prod_last_r <= 1'b0;
      acc_done_r  <= 1'b0;
      sat_vld_r   <= 1'b0;
      res_vld_r   <= 1'b0;
    end else begin
      prod_vld_r  <= ctl.tap_vld;
      prod_last_r <= ctl.tap_vld & ctl.tap_last;
      acc_done_r  <= prod_vld_r & prod_last_r;
      sat_vld_r   <= acc_done_r;
      res_vld_r   <= sat_vld_r;
    end

    if (ctl.start) begin
      coef_r <= gain;
    end else if (ctl.tap_vld) begin
      coef_r <= coef_nxt;
    end

    prod_r <= $signed(tap_data) * $signed({1'b0, coef_r});

    if (ctl.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end

    if (acc_done_r) begin
      if (acc_r > LIM_HI) begin
        sat_r      <= LIM_HI;
        sat_clip_r <= 1'b1;
      end else if (acc_r < LIM_LO) begin
        sat_r      <= LIM_LO;
        sat_clip_r <= 1'b1;
      end else begin
        sat_r      <= acc_r;
        sat_clip_r <= 1'b0;
      end
    end

    if (sat_vld_r) begin
      res_sample_r <= rnd[16 +: SAMPLE_W];
      res_clip_r   <= sat_clip_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/exponential_decay_fir_reverb_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exponential_decay_fir_reverb_unit
// Each input beat starts TAPS history reads, one read per cycle through the
//   single read port.
// Input beats are taken only while idle, one at a time; the next input is
//   taken while a result waits in the output register.
// Reset: history reads as zero until written (fill count), gain and ratio to defaults.
// ----------------------------------------------------------------------------
module exponential_decay_fir_reverb_unit #(
  parameter int SEGMENT_COUNT = efr_pkg::SEGMENT_COUNT_DEF,
  parameter int SEGMENT_TAPS  = efr_pkg::SEGMENT_TAPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [efr_pkg::SAMPLE_W-1:0]     in_tdata,    // [31:0] sample_in
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [efr_pkg::SAMPLE_W-1:0]          out_tdata,   // [31:0] sample_out
  output logic                                  out_tuser,   // [0] clipped
  input  wire logic                             cfg_wr_en,
  input  wire logic [efr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [efr_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import efr_pkg::*;

  localparam int TAPS   = SEGMENT_COUNT * SEGMENT_TAPS;
  localparam int PTR_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W = $clog2(TAPS + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(TAPS - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(TAPS);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

  state_t              state_r;
  logic [COEF_W-1:0]   gain_r;
  logic [COEF_W-1:0]   ratio_r;
  logic [PTR_W-1:0]    wp_r;
  logic [FILL_W-1:0]   fill_r;
  logic [PTR_W-1:0]    iss_idx_r;
  logic [PTR_W-1:0]    iss_cnt_r;
  logic                issuing_r;
  logic                rd_vld_r;
  logic                rd_ok_r;
  logic                rd_last_r;
  logic                out_tvalid_r;
  logic [SAMPLE_W-1:0] out_tdata_r;
  logic                out_tuser_r;
  logic                in_beat;
  logic                mem_we;
  logic [SAMPLE_W-1:0] mem_rdata;
  efr_mac_ctl_t        mac_ctl;
  logic                res_vld;
  logic [SAMPLE_W-1:0] res_sample;
  logic                res_clip;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid & in_tready;
  assign mem_we     = in_beat;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign mac_ctl.start    = in_beat;
  assign mac_ctl.tap_vld  = rd_vld_r;
  assign mac_ctl.tap_last = rd_last_r;

  efr_hist_mem #(
    .DEPTH (TAPS),
    .AW    (PTR_W),
    .W     (SAMPLE_W)
  ) u_hist (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (wp_r),
    .wdata   (in_tdata),
    .raddr   (iss_idx_r),
    .rdata_r (mem_rdata)
  );

  efr_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (mac_ctl),
    .tap_data     (rd_ok_r ? mem_rdata : '0),
    .gain         (gain_r),
    .ratio        (ratio_r),
    .res_vld_r    (res_vld),
    .res_sample_r (res_sample),
    .res_clip_r   (res_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gain_r       <= GAIN_RESET;
      ratio_r      <= RATIO_RESET;
      wp_r         <= '0;
      fill_r       <= '0;
      issuing_r    <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_KERNEL_GAIN: gain_r  <= cfg_wr_data;
          REG_DECAY_RATIO: ratio_r <= cfg_wr_data;
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && (state_r != ST_WAIT)) begin
        out_tvalid_r <= 1'b0;
      end

      rd_vld_r  <= issuing_r;
      rd_ok_r   <= FILL_W'(iss_idx_r) < fill_r;
      rd_last_r <= (iss_cnt_r == LAST_PTR);

      if (issuing_r) begin
        iss_idx_r <= (iss_idx_r == '0) ? LAST_PTR : iss_idx_r - 1'b1;
        iss_cnt_r <= iss_cnt_r + 1'b1;
        if (iss_cnt_r == LAST_PTR) begin
          issuing_r <= 1'b0;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            iss_idx_r <= wp_r;
            iss_cnt_r <= '0;
            issuing_r <= 1'b1;
            wp_r      <= (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
            if (fill_r != FULL_CNT) begin
              fill_r <= fill_r + 1'b1;
            end
            state_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (res_vld) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_sample;
            out_tuser_r  <= res_clip;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
